[src/qfs_pkg.sv]
// qfs_pkg: shared types and constants for the quoted field splitter.
// Used by the stream interface and the core. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qfs_pkg;

	localparam int MaxFieldsDefault = 64;

	localparam logic [7:0] QuoteByte      = 8'h22;
	localparam logic [7:0] DelimReset     = 8'd44;
	localparam logic [6:0] MaxFieldsReset = 7'd64;

	// configuration register indexes
	typedef enum logic [0:0] {
		RegDelimiter = 1'b0,
		RegMaxFields = 1'b1
	} reg_index_t;

	// handling of a field that opens with a double quote
	typedef enum logic [2:0] {
		StripNone = 3'b001,
		StripOpen = 3'b010,
		StripDone = 3'b100
	} strip_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       keep;
		logic [5:0] field_index;
		logic       field_end;
		logic [6:0] field_count;
		logic       end_of_string;
	} out_item_t;

endpackage

`default_nettype wire

[src/qfs_stream_if.sv]
// qfs_stream_if: valid/ready stream carrying one item per request.
// Payload type is a parameter; items come from qfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qfs_stream_if #(
	parameter type item_t = qfs_pkg::in_item_t
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/quoted_field_splitter_core.sv]
// quoted_field_splitter_core: splits a byte stream into fields at a delimiter,
// honouring double quotes. Depends on qfs_pkg and qfs_stream_if.
//
// Pipeline: an accepted request lands in the input register, and the per-byte
// step then loads its result into the result register. Throughput: one byte
// per cycle while results.ready holds, set by the single combinational step
// between the two registers.
// Reset (arst_n low): pipeline empties, delimiter 44, max_fields 64, field
// state back to start of string.
`timescale 1ns / 1ps
`default_nettype none

module quoted_field_splitter_core #(
	parameter int MaxFields = qfs_pkg::MaxFieldsDefault
) (
	input  wire        clk,
	input  wire        arst_n,
	qfs_stream_if.sink   bytes,
	qfs_stream_if.source results,
	input  wire        wr_en,
	input  wire  [0:0] wr_index,
	input  wire  [7:0] wr_data
);

	localparam int CurW = (MaxFields > 1) ? $clog2(MaxFields) : 1;
	localparam int LimW = ($clog2(MaxFields + 1) > 7) ? $clog2(MaxFields + 1) : 7;
	localparam int ExtW = LimW + 7;

	logic [7:0] delim_q;
	logic [6:0] maxf_q;

	logic            quote_q, quote_nxt;
	logic [CurW-1:0] field_q, field_nxt;
	logic            start_q, start_nxt;
	qfs_pkg::strip_t strip_q, strip_nxt;

	logic                 valid_s1;
	qfs_pkg::in_item_t    item_s1;
	logic                 valid_s2;
	qfs_pkg::out_item_t   item_s2;
	qfs_pkg::out_item_t   res;

	logic advance;

	assign advance       = !valid_s2 || results.ready;
	assign bytes.ready   = !valid_s1 || advance;
	assign results.valid = valid_s2;
	assign results.data  = item_s2;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= qfs_pkg::DelimReset;
			maxf_q  <= qfs_pkg::MaxFieldsReset;
		end else if (wr_en) begin
			case (qfs_pkg::reg_index_t'(wr_index))
				qfs_pkg::RegDelimiter: delim_q <= wr_data;
				qfs_pkg::RegMaxFields: maxf_q  <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	// per-byte step
	logic [LimW-1:0] limit, maxf_ext, fld_inc;
	logic [ExtW-1:0] idx_ext, cnt_ext;
	logic            is_quote, splittable, is_delim, active;

	always_comb begin
		maxf_ext   = LimW'(maxf_q);
		limit      = (maxf_ext > LimW'(MaxFields)) ? LimW'(MaxFields) : maxf_ext;
		active     = (limit != '0);
		fld_inc    = LimW'(field_q) + LimW'(1);
		is_quote   = (item_s1.data_byte == qfs_pkg::QuoteByte);
		splittable = (fld_inc < limit);
		is_delim   = !is_quote && (item_s1.data_byte == delim_q) && !quote_q && splittable;
		idx_ext    = ExtW'(field_q);
		cnt_ext    = ExtW'(fld_inc);

		quote_nxt = quote_q;
		field_nxt = field_q;
		start_nxt = start_q;
		strip_nxt = strip_q;

		res.out_byte      = item_s1.data_byte;
		res.keep          = 1'b0;
		res.field_index   = '0;
		res.field_end     = 1'b0;
		res.field_count   = '0;
		res.end_of_string = item_s1.last;

		if (active) begin
			res.field_index = idx_ext[5:0];
			res.field_count = cnt_ext[6:0];
			if (is_delim) begin
				res.field_end = 1'b1;
				field_nxt     = field_q + CurW'(1);
				start_nxt     = 1'b1;
				strip_nxt     = qfs_pkg::StripNone;
			end else begin
				if (start_q) begin
					strip_nxt = is_quote ? qfs_pkg::StripOpen : qfs_pkg::StripNone;
					res.keep  = !is_quote;
				end else begin
					case (strip_q)
						qfs_pkg::StripNone: res.keep = 1'b1;
						qfs_pkg::StripOpen: begin
							res.keep = !is_quote;
							if (is_quote) begin
								strip_nxt = qfs_pkg::StripDone;
							end
						end
						default: res.keep = 1'b0;
					endcase
				end
				start_nxt     = 1'b0;
				res.field_end = item_s1.last;
			end
			if (is_quote) begin
				quote_nxt = !quote_q;
			end
		end

		if (item_s1.last) begin
			quote_nxt = 1'b0;
			field_nxt = '0;
			start_nxt = 1'b1;
			strip_nxt = qfs_pkg::StripNone;
		end
	end

	// control and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			quote_q  <= 1'b0;
			field_q  <= '0;
			start_q  <= 1'b1;
			strip_q  <= qfs_pkg::StripNone;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					quote_q <= quote_nxt;
					field_q <= field_nxt;
					start_q <= start_nxt;
					strip_q <= strip_nxt;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1 <= bytes.data;
		end
		if (advance && valid_s1) begin
			item_s2 <= res;
		end
	end

endmodule

`default_nettype wire
